[design/prefixed_hex_crc8_decoder_defines.svh]
// Assertion macros shared by the decoder RTL.
`ifndef PREFIXED_HEX_CRC8_DECODER_DEFINES_SVH
`define PREFIXED_HEX_CRC8_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PHCRC_ASSERT_NOW(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (cond) |-> (conseq)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define PHCRC_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (cond) |=> (conseq)) else $error(msg);

`endif

[design/phcrc_pkg.sv]
package phcrc_pkg;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    localparam logic [2:0] POS_FULL = 3'd5;
    localparam logic [2:0] POS_P0   = 3'd0;
    localparam logic [2:0] POS_P1   = 3'd1;
    localparam logic [2:0] POS_P2   = 3'd2;

    localparam logic [7:0] CH_I_LO = 8'h69;
    localparam logic [7:0] CH_I_UP = 8'h49;
    localparam logic [7:0] CH_C_LO = 8'h63;
    localparam logic [7:0] CH_C_UP = 8'h43;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_F_UP = 8'h46;
    // 'A' - 10: letters map to their nibble by subtracting this
    localparam logic [7:0] LETTER_BIAS = 8'd55;

    localparam logic [7:0] CRC_POLY = 8'h07;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_SCHEME    = 3'd2,
        ST_BAD_HEX   = 3'd3,
        ST_ODD_COUNT = 3'd4,
        ST_CRC_BAD   = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] url_char;
        logic       final_char;
    } t_in_item;

    typedef struct packed {
        logic       is_status;
        logic [7:0] data_byte;
        logic [2:0] status_code;
        logic       run_end;
    } t_out_item;

    // One queued record: the results that one character causes.
    typedef struct packed {
        logic       has_data;
        logic [7:0] data_byte;
        logic       data_end;
        logic       has_status;
        t_status    status_code;
    } t_work;

    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
        end
        return v;
    endfunction

endpackage

[design/phcrc_front.sv]
module phcrc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  phcrc_pkg::t_in_item i_item,
    output logic               o_push,
    output phcrc_pkg::t_work   o_work
);

    logic [2:0] r_pos, n_pos;
    logic       r_phase, n_phase;
    logic [3:0] r_hi, n_hi;
    logic [7:0] r_held, n_held;
    logic       r_held_v, n_held_v;
    logic [7:0] r_crc, n_crc;
    logic       r_scheme_err, n_scheme_err;
    logic       r_hex_err, n_hex_err;

    logic [7:0] c;
    logic       is_digit, is_letter, hex_ok;
    logic [3:0] nib;
    logic [7:0] letter_val;
    logic       emit;
    phcrc_pkg::t_status code;

    assign c          = i_item.url_char;
    assign is_digit   = (c >= phcrc_pkg::CH_ZERO) && (c <= phcrc_pkg::CH_NINE);
    assign is_letter  = (c >= phcrc_pkg::CH_A_UP) && (c <= phcrc_pkg::CH_F_UP);
    assign hex_ok     = is_digit || is_letter;
    assign letter_val = c - phcrc_pkg::LETTER_BIAS;
    assign nib        = is_digit ? c[3:0] : letter_val[3:0];

    always_comb begin
        n_pos        = r_pos;
        n_phase      = r_phase;
        n_hi         = r_hi;
        n_held       = r_held;
        n_held_v     = r_held_v;
        n_crc        = r_crc;
        n_scheme_err = r_scheme_err;
        n_hex_err    = r_hex_err;
        emit         = 1'b0;

        case (r_pos)
            phcrc_pkg::POS_P0: begin
                if (c != phcrc_pkg::CH_I_LO && c != phcrc_pkg::CH_I_UP) n_scheme_err = 1'b1;
            end
            phcrc_pkg::POS_P1: begin
                if (c != phcrc_pkg::CH_C_LO && c != phcrc_pkg::CH_C_UP) n_scheme_err = 1'b1;
            end
            phcrc_pkg::POS_P2: begin
                if (c != phcrc_pkg::CH_COLON) n_scheme_err = 1'b1;
            end
            default: begin
                if (!hex_ok) n_hex_err = 1'b1;
                if (!r_phase) begin
                    n_hi    = nib;
                    n_phase = 1'b1;
                end else begin
                    n_phase = 1'b0;
                    // release the byte held back by one pair
                    if (r_held_v) begin
                        emit  = 1'b1;
                        n_crc = phcrc_pkg::crc_fold(r_crc, r_held);
                    end
                    n_held   = {r_hi, nib};
                    n_held_v = 1'b1;
                end
            end
        endcase

        if (r_pos < phcrc_pkg::POS_FULL) n_pos = r_pos + 3'd1;

        if (n_pos < phcrc_pkg::POS_FULL)           code = phcrc_pkg::ST_SHORT;
        else if (n_scheme_err)                      code = phcrc_pkg::ST_SCHEME;
        else if (n_hex_err)                         code = phcrc_pkg::ST_BAD_HEX;
        else if (n_phase)                           code = phcrc_pkg::ST_ODD_COUNT;
        else if (!n_held_v || n_crc != n_held)      code = phcrc_pkg::ST_CRC_BAD;
        else                                        code = phcrc_pkg::ST_OK;

        o_work.has_data    = emit;
        o_work.data_byte   = r_held;
        o_work.data_end    = !i_item.final_char;
        o_work.has_status  = i_item.final_char;
        o_work.status_code = code;

        // clear all text state after the final character
        if (i_item.final_char) begin
            n_pos        = '0;
            n_phase      = 1'b0;
            n_hi         = '0;
            n_held       = '0;
            n_held_v     = 1'b0;
            n_crc        = '0;
            n_scheme_err = 1'b0;
            n_hex_err    = 1'b0;
        end
    end

    assign o_push = i_accept && (emit || i_item.final_char);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_phase      <= 1'b0;
            r_hi         <= '0;
            r_held       <= '0;
            r_held_v     <= 1'b0;
            r_crc        <= '0;
            r_scheme_err <= 1'b0;
            r_hex_err    <= 1'b0;
        end else if (i_accept) begin
            r_pos        <= n_pos;
            r_phase      <= n_phase;
            r_hi         <= n_hi;
            r_held       <= n_held;
            r_held_v     <= n_held_v;
            r_crc        <= n_crc;
            r_scheme_err <= n_scheme_err;
            r_hex_err    <= n_hex_err;
        end
    end

endmodule

[design/phcrc_fifo.sv]
module phcrc_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  phcrc_pkg::t_work i_wdata,
    input  logic             i_pop,
    output phcrc_pkg::t_work o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int unsigned AW = phcrc_pkg::Q_AW;

    phcrc_pkg::t_work r_mem [phcrc_pkg::Q_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == (AW+1)'(phcrc_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + AW'(1);
            if (do_pop)  r_rd <= r_rd + AW'(1);
            r_count <= r_count + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

endmodule

[design/phcrc_back.sv]
module phcrc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  phcrc_pkg::t_work     i_work,
    input  logic                 i_avail,
    input  logic                 i_pop,
    output logic                 o_take,
    output logic                 o_empty,
    output phcrc_pkg::t_out_item o_result
);

    logic r_second;
    logic show_data, fire;

    // data goes first when the record has both
    assign show_data = i_work.has_data && !r_second;
    assign o_empty   = !i_avail;
    assign fire      = i_pop && i_avail;
    assign o_take    = fire && !(show_data && i_work.has_status);

    always_comb begin
        if (show_data) begin
            o_result.is_status   = 1'b0;
            o_result.data_byte   = i_work.data_byte;
            o_result.status_code = phcrc_pkg::ST_OK;
            o_result.run_end     = i_work.data_end;
        end else begin
            o_result.is_status   = 1'b1;
            o_result.data_byte   = '0;
            o_result.status_code = i_work.status_code;
            o_result.run_end     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else if (fire) begin
            r_second <= show_data && i_work.has_status;
        end
    end

endmodule

[design/prefixed_hex_crc8_decoder.sv]
// Prefixed hex decoder with CRC-8 check.
// Input channel: i_item carries one character and its final mark; a character
// is taken on a rising edge with push high and full low. A text must start with
// i/I, c/C and a colon, followed by uppercase hex digit pairs whose last pair is
// a CRC-8 (poly 0x07, init 0) over the bytes before it.
// Result channel: o_result holds the oldest result while empty is low; it is
// taken on a rising edge with pop high. Each data byte comes out one pair late;
// the final character yields the status (0 ok, else a failure code), after
// which bytes already delivered must be discarded on failure.
// Throughput: one character per cycle while full is low; classify, pair and
// CRC update are combinational in the front stage. Each result is written
// into the queue on the edge that takes its character. A final character
// with a pending byte yields two results, taken on two pops.
// Up to four records sit in the queue between front and back; when the
// receiver stalls the queue fills and full rises, holding off the sender.
// Reset (synchronous, active low) clears the text state and empties the queue.
`include "prefixed_hex_crc8_decoder_defines.svh"

module prefixed_hex_crc8_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  phcrc_pkg::t_in_item  i_item,
    output logic                 empty,
    input  logic                 pop,
    output phcrc_pkg::t_out_item o_result
);

    logic             accept;
    logic             work_push;
    logic             work_take;
    logic             q_empty;
    phcrc_pkg::t_work work_in, work_out;

    assign accept = push && !full;

    phcrc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_push   (work_push),
        .o_work   (work_in)
    );

    phcrc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (work_push),
        .i_wdata (work_in),
        .i_pop   (work_take),
        .o_rdata (work_out),
        .o_full  (full),
        .o_empty (q_empty)
    );

    phcrc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_work   (work_out),
        .i_avail  (!q_empty),
        .i_pop    (pop),
        .o_take   (work_take),
        .o_empty  (empty),
        .o_result (o_result)
    );

    `PHCRC_ASSERT_NOW(a_full_has_result, i_clk, i_rst_n, full, !empty, "queue full but no result shown")
    `PHCRC_ASSERT_NOW(a_status_zero_byte, i_clk, i_rst_n, !empty && o_result.is_status, o_result.data_byte == 8'd0, "status result with nonzero byte")
    `PHCRC_ASSERT_NEXT(a_data_then_status, i_clk, i_rst_n, pop && !empty && !o_result.is_status && !o_result.run_end, !empty && o_result.is_status, "final data byte not followed by status")

endmodule
